// ===== rtl/core/dltq_pkg.sv =====
// Package for the delta-list timer queue: shared constants, codes and the
// sequencer-to-datapath struct. No dependencies.
package dltq_pkg;

  localparam int unsigned MaxTimersDefault = 32;
  localparam int unsigned RunCap = 63;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_STOP    = 3'd1,
    MODE_ADVANCE = 3'd2,
    MODE_SET     = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_EXPIRY  = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_NOTFND  = 3'd3,
    KIND_CUT     = 3'd4
  } kind_e;

  typedef struct packed {
    logic        start;
    logic [31:0] multiplier;
    logic [47:0] multiplicand;
  } mul_req_t;

endpackage

// ===== rtl/core/dltq_mul.sv =====
// Iterative saturating multiplier for the timer queue: 48-bit period times
// 32-bit scale, one scale bit per cycle. Depends on dltq_pkg.
module dltq_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dltq_pkg::mul_req_t req_i,
  output logic               busy_o,
  output logic [63:0]        product_o
);
  import dltq_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] mplr_q, mplr_d;
  logic [79:0] acc_q, acc_d;
  logic [47:0] mcnd_q, mcnd_d;

  always_comb begin
    cnt_d  = cnt_q;
    mplr_d = mplr_q;
    acc_d  = acc_q;
    mcnd_d = mcnd_q;
    if (req_i.start) begin
      cnt_d  = 6'd32;
      mplr_d = req_i.multiplier;
      mcnd_d = req_i.multiplicand;
      acc_d  = '0;
    end else if (cnt_q != 6'd0) begin
      acc_d  = {acc_q[78:0], 1'b0} + (mplr_q[31] ? {32'd0, mcnd_q} : 80'd0);
      mplr_d = {mplr_q[30:0], 1'b0};
      cnt_d  = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplr_q <= mplr_d;
    acc_q  <= acc_d;
    mcnd_q <= mcnd_d;
  end

  assign busy_o    = (cnt_q != 6'd0) || req_i.start;
  assign product_o = (acc_q[79:64] != 16'd0) ? {64{1'b1}} : acc_q[63:0];

endmodule

// ===== rtl/core/delta_list_timer_queue.sv =====
// Top level of the delta-list timer queue: sequencer, entry memory and the
// iterative multiplier instance. Depends on dltq_pkg and dltq_mul.
//
//   channel  | handshake                | payload
//   in       | in_valid_i/in_stall_o    | mode, timer tag, timeout, recurring, time value
//   out      | out_valid_o/out_stall_i  | kind, expired id, remaining units, up time, last
//   cfg      | cfg_we_i                 | cfg_wdata_i (scale)
//
// An add that lands at the tail takes the request, runs the bit-serial multiply
// and writes the entry, then hands over the result. Landing earlier adds a read
// and a compare per entry compared and a read and a write per entry moved. A stop
// reads and compares each entry searched and moves later entries down. An expiry
// is removed, and re-added if it recurs. Reset empties the table without touching
// the entry memory, and a stalled result holds the sequencer.
module delta_list_timer_queue #(
  parameter int unsigned MAX_TIMERS = dltq_pkg::MaxTimersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] timer_tag_i,
  input  logic [47:0] timeout_units_i,
  input  logic        recurring_i,
  input  logic [63:0] time_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] expired_id_o,
  output logic [63:0] remaining_units_o,
  output logic [63:0] now_units_o,
  output logic        last_o
);
  import dltq_pkg::*;

  localparam int unsigned AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned EW = 64 + 32 + 48 + 1;

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_MUL    = 17'b00000000000000010,
    S_WK_RD  = 17'b00000000000000100,
    S_WK_CK  = 17'b00000000000001000,
    S_SH_RD  = 17'b00000000000010000,
    S_SH_WR  = 17'b00000000000100000,
    S_ST_RD  = 17'b00000000001000000,
    S_ST_CK  = 17'b00000000010000000,
    S_RM_RD  = 17'b00000000100000000,
    S_RM_WR  = 17'b00000001000000000,
    S_A_CHK  = 17'b00000010000000000,
    S_A_DEC  = 17'b00000100000000000,
    S_A_ERD  = 17'b00001000000000000,
    S_A_EXP  = 17'b00010000000000000,
    S_SET_RD = 17'b00100000000000000,
    S_SET_WR = 17'b01000000000000000,
    S_OUT    = 17'b10000000000000000
  } state_e;

  typedef enum logic [1:0] {
    AFTER_DONE = 2'd0,
    AFTER_ADV  = 2'd1
  } after_e;

  state_e      state_q, state_d;
  after_e      ret_q, ret_d;
  logic [31:0] scale_q;
  logic [CW-1:0] count_q, count_d;
  logic [63:0] tail_q, tail_d, up_q, up_d;

  logic [EW-1:0] mem [MAX_TIMERS];
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [CW-1:0] pos_q, pos_d, idx_q, idx_d;
  logic [63:0] d_q, d_d, units_q, units_d;
  logic [31:0] id_q, id_d;
  logic [47:0] per_q, per_d;
  logic        rec_q, rec_d;
  logic        first_q, first_d;
  logic [6:0]  n_q, n_d;
  logic [2:0]  okind_q, okind_d;
  logic [31:0] oid_q, oid_d;
  logic [63:0] orem_q, orem_d;
  logic        olast_q, olast_d;
  logic        ov_q, ov_d;

  mul_req_t    mreq;
  logic        mbusy;
  logic [63:0] mprod;

  dltq_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mreq),
    .busy_o   (mbusy),
    .product_o(mprod)
  );

  logic [63:0] rd_delta;
  logic [31:0] rd_id;
  logic [47:0] rd_per;
  logic        rd_rec;
  assign rd_delta = rdata_q[EW-1 -: 64];
  assign rd_id    = rdata_q[EW-65 -: 32];
  assign rd_per   = rdata_q[48:1];
  assign rd_rec   = rdata_q[0];

  logic [AW-1:0] pos_a, idx_a;
  assign pos_a = pos_q[AW-1:0];
  assign idx_a = idx_q[AW-1:0];

  logic [63:0] adv_step;
  assign adv_step = (rd_delta < units_q) ? rd_delta : units_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    count_d = count_q;  tail_d = tail_q;  up_d = up_q;
    pos_d = pos_q;  idx_d = idx_q;  d_d = d_q;  units_d = units_q;
    id_d = id_q;  per_d = per_q;  rec_d = rec_q;  first_d = first_q;
    n_d = n_q;
    okind_d = okind_q;  oid_d = oid_q;  orem_d = orem_q;  olast_d = olast_q;
    ov_d = ov_q;
    raddr = '0;  we = 1'b0;  waddr = pos_a;  wdata = rdata_q;
    mreq.start = 1'b0;  mreq.multiplier = scale_q;  mreq.multiplicand = per_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d = timer_tag_i;  per_d = timeout_units_i;  rec_d = recurring_i;
          units_d = time_value_i;  n_d = '0;
          okind_d = KIND_DONE;  oid_d = '0;  orem_d = '0;  olast_d = 1'b1;
          ret_d = AFTER_DONE;
          case (mode_i)
            MODE_ADD: begin
              if (count_q >= CW'(MAX_TIMERS)) begin
                okind_d = KIND_FULL;  state_d = S_OUT;
              end else begin
                mreq.start = 1'b1;  mreq.multiplicand = timeout_units_i;
                state_d = S_MUL;
              end
            end
            MODE_STOP: begin
              pos_d = '0;  state_d = S_ST_RD;
            end
            MODE_ADVANCE: begin
              state_d = S_A_CHK;
            end
            MODE_SET: begin
              if (time_value_i > up_q) begin
                units_d = time_value_i - up_q;  state_d = S_A_CHK;
              end else begin
                d_d = up_q - time_value_i;
                up_d = time_value_i;
                state_d = (count_q != '0) ? S_SET_RD : S_OUT;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;  tail_d = '0;  up_d = '0;  state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SET_RD: begin
        raddr = '0;
        if (d_q > ~tail_q) begin
          d_d = ~tail_q;
        end
        state_d = S_SET_WR;
      end
      S_SET_WR: begin
        we = 1'b1;  waddr = '0;
        wdata = {rd_delta + d_q, rd_id, rd_per, rd_rec};
        tail_d = tail_q + d_q;
        state_d = S_OUT;
      end
      S_MUL: begin
        if (!mbusy) begin
          if (mprod >= tail_q) begin
            we = 1'b1;  waddr = count_q[AW-1:0];
            wdata = {mprod - tail_q, id_q, per_q, rec_q};
            tail_d = mprod;
            count_d = count_q + CW'(1);
            state_d = S_OUT;
          end else begin
            d_d = mprod;  pos_d = '0;
            state_d = S_WK_RD;
          end
        end
      end
      S_WK_RD: begin
        raddr = pos_a;
        state_d = S_WK_CK;
      end
      S_WK_CK: begin
        if (pos_q < count_q && rd_delta <= d_q) begin
          d_d = d_q - rd_delta;
          pos_d = pos_q + CW'(1);
          state_d = S_WK_RD;
        end else begin
          if (pos_q >= count_q) begin
            tail_d = tail_q + d_q;
          end
          idx_d = count_q;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (idx_q == pos_q) begin
          we = 1'b1;  waddr = pos_a;
          wdata = {d_q, id_q, per_q, rec_q};
          count_d = count_q + CW'(1);
          state_d = S_OUT;
        end else begin
          raddr = idx_a - AW'(1);
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we = 1'b1;  waddr = idx_a;
        if (idx_q - CW'(1) == pos_q) begin
          wdata = {rd_delta - d_q, rd_id, rd_per, rd_rec};
        end
        idx_d = idx_q - CW'(1);
        state_d = S_SH_RD;
      end
      S_ST_RD: begin
        if (pos_q >= count_q) begin
          okind_d = KIND_NOTFND;  state_d = S_OUT;
        end else begin
          raddr = pos_a;
          state_d = S_ST_CK;
        end
      end
      S_ST_CK: begin
        if (rd_id == id_q) begin
          d_d = rd_delta;  first_d = 1'b1;
          state_d = S_RM_RD;
        end else begin
          pos_d = pos_q + CW'(1);
          state_d = S_ST_RD;
        end
      end
      S_RM_RD: begin
        if (pos_q + CW'(1) >= count_q) begin
          count_d = count_q - CW'(1);
          if (first_q) begin
            tail_d = tail_q - d_q;
          end
          if (ret_q == AFTER_ADV && rec_q) begin
            mreq.start = 1'b1;
            state_d = S_MUL;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          raddr = pos_a + AW'(1);
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        we = 1'b1;  waddr = pos_a;
        if (first_q) begin
          wdata = {rd_delta + d_q, rd_id, rd_per, rd_rec};
        end
        first_d = 1'b0;
        pos_d = pos_q + CW'(1);
        state_d = S_RM_RD;
      end
      S_A_CHK: begin
        if (units_q == 64'd0) begin
          okind_d = KIND_DONE;  oid_d = '0;  orem_d = '0;  olast_d = 1'b1;
          ret_d = AFTER_DONE;  state_d = S_OUT;
        end else if (count_q == '0) begin
          up_d = up_q + units_q;  units_d = '0;
        end else begin
          raddr = '0;
          state_d = S_A_DEC;
        end
      end
      S_A_DEC: begin
        we = 1'b1;  waddr = '0;
        wdata = {rd_delta - adv_step, rd_id, rd_per, rd_rec};
        tail_d = tail_q - adv_step;
        up_d = up_q + adv_step;
        units_d = units_q - adv_step;
        state_d = (rd_delta <= units_q) ? S_A_ERD : S_A_CHK;
      end
      S_A_ERD: begin
        if (count_q == '0) begin
          state_d = S_A_CHK;
        end else begin
          raddr = '0;
          state_d = S_A_EXP;
        end
      end
      S_A_EXP: begin
        if (rd_delta != 64'd0) begin
          state_d = S_A_CHK;
        end else if (n_q >= 7'(RunCap)) begin
          okind_d = KIND_CUT;  orem_d = units_q;  olast_d = 1'b1;
          oid_d = '0;  ret_d = AFTER_DONE;  state_d = S_OUT;
        end else begin
          id_d = rd_id;  per_d = rd_per;  rec_d = rd_rec;
          n_d = n_q + 7'd1;
          okind_d = KIND_EXPIRY;  oid_d = rd_id;  orem_d = '0;  olast_d = 1'b0;
          ret_d = AFTER_ADV;
          pos_d = '0;  d_d = rd_delta;  first_d = 1'b1;
          state_d = S_RM_RD;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          state_d = (ret_q == AFTER_ADV) ? S_A_ERD : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register; the outgoing result is captured when S_OUT fires.
  logic [2:0]  r_kind_q;
  logic [31:0] r_id_q;
  logic [63:0] r_rem_q, r_time_q;
  logic        r_last_q;
  logic        fire;
  assign fire = (state_q == S_OUT) && (!ov_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_kind_q <= okind_q;
      r_id_q   <= (okind_q == KIND_EXPIRY) ? oid_q : 32'd0;
      r_rem_q  <= (okind_q == KIND_CUT) ? orem_q : 64'd0;
      r_time_q <= up_q;
      r_last_q <= olast_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= AFTER_DONE;
      scale_q <= 32'd1;
      count_q <= '0;
      tail_q  <= '0;
      up_q    <= '0;
      ov_q    <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      tail_q  <= tail_d;
      up_q    <= up_d;
      ov_q    <= ov_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    d_q     <= d_d;
    units_q <= units_d;
    id_q    <= id_d;
    per_q   <= per_d;
    rec_q   <= rec_d;
    first_q <= first_d;
    okind_q <= okind_d;
    oid_q   <= oid_d;
    orem_q  <= orem_d;
    olast_q <= olast_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = ov_q;
  assign kind_o            = r_kind_q;
  assign expired_id_o      = r_id_q;
  assign remaining_units_o = r_rem_q;
  assign now_units_o       = r_time_q;
  assign last_o            = r_last_q;

endmodule

// ===== rtl/core/dltq_checker.sv =====
// Port-level checker for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg.
module dltq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [31:0] expired_id_o,
  input logic [63:0] remaining_units_o,
  input logic        last_o
);
  import dltq_pkg::*;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted request did not make the block busy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_EXPIRY) != last_o)
    else $error("last flag does not match kind");

  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_EXPIRY |-> expired_id_o == 32'd0)
    else $error("id on non-expiry result");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_CUT |-> remaining_units_o == 64'd0)
    else $error("remaining units on wrong kind");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the delta-list timer queue: drives add, stop, advance, set
// time, clear and undefined-mode requests and checks every result against a
// built-in predictor. Depends on dltq_pkg and the delta_list_timer_queue RTL.
module tb;
  import dltq_pkg::*;

  localparam int unsigned NumTimers = MaxTimersDefault;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [63:0] rem;
    logic [63:0] now;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [31:0] timer_tag_i = '0;
  logic [47:0] timeout_units_i = '0;
  logic        recurring_i = 1'b0;
  logic [63:0] time_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] expired_id_o;
  logic [63:0] remaining_units_o;
  logic [63:0] now_units_o;
  logic        last_o;

  delta_list_timer_queue DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] scale_q;
  logic [63:0] q_delta [NumTimers];
  logic [31:0] q_id [NumTimers];
  logic [47:0] q_period [NumTimers];
  logic        q_rec [NumTimers];
  int unsigned q_count;
  logic [63:0] q_tail;
  logic [63:0] q_now;

  result_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned expiries_seen = 0;

  function automatic logic [63:0] scaled_timeout(logic [47:0] period);
    logic [127:0] p;
    p = period * scale_q;
    return (p[127:64] != 0) ? AllOnes : p[63:0];
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_count; i++) begin
      q_delta[i] = q_delta[i+1];
      q_id[i] = q_id[i+1];
      q_period[i] = q_period[i+1];
      q_rec[i] = q_rec[i+1];
    end
    q_count--;
  endfunction

  function automatic bit insert_timer(logic [31:0] id, logic [47:0] period, logic rec);
    logic [63:0] t;
    logic [63:0] d;
    int unsigned pos;
    if (q_count >= NumTimers) return 1'b0;
    t = scaled_timeout(period);
    if (t >= q_tail) begin
      pos = q_count;
      d = t - q_tail;
      q_tail = t;
    end else begin
      pos = 0;
      d = t;
      while (pos < q_count && q_delta[pos] <= d) begin
        d -= q_delta[pos];
        pos++;
      end
      if (pos < q_count) q_delta[pos] -= d;
      else q_tail += d;
    end
    for (int unsigned i = q_count; i > pos; i--) begin
      q_delta[i] = q_delta[i-1];
      q_id[i] = q_id[i-1];
      q_period[i] = q_period[i-1];
      q_rec[i] = q_rec[i-1];
    end
    q_delta[pos] = d;
    q_id[pos] = id;
    q_period[pos] = period;
    q_rec[pos] = rec;
    q_count++;
    return 1'b1;
  endfunction

  function automatic void push_result(kind_e k, logic [31:0] id, logic [63:0] rem, logic last);
    result_t r;
    r.kind = k;
    r.id = id;
    r.rem = rem;
    r.now = q_now;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_advance(logic [63:0] units);
    int n;
    logic [63:0] dec;
    logic [31:0] id;
    logic [47:0] per;
    logic rec;
    n = 0;
    while (units != 0) begin
      dec = units;
      if (q_count > 0) begin
        if (q_delta[0] < dec) dec = q_delta[0];
        q_delta[0] -= dec;
        q_tail -= dec;
      end
      q_now += dec;
      units -= dec;
      while (q_count > 0 && q_delta[0] == 0) begin
        if (n >= RunCap) begin
          push_result(KIND_CUT, '0, units, 1'b1);
          return;
        end
        id = q_id[0];
        per = q_period[0];
        rec = q_rec[0];
        drop_entry(0);
        if (rec) void'(insert_timer(id, per, rec));
        push_result(KIND_EXPIRY, id, '0, 1'b0);
        n++;
      end
    end
    push_result(KIND_DONE, '0, '0, 1'b1);
  endfunction

  function automatic void predict_request(logic [2:0] mode, logic [31:0] id,
                                          logic [47:0] tmo, logic rec, logic [63:0] tv);
    logic [63:0] add;
    bit found;
    case (mode)
      MODE_ADD: push_result(insert_timer(id, tmo, rec) ? KIND_DONE : KIND_FULL, '0, '0, 1'b1);
      MODE_STOP: begin
        found = 1'b0;
        for (int unsigned i = 0; i < q_count && !found; i++) begin
          if (q_id[i] == id) begin
            if (i + 1 < q_count) q_delta[i+1] += q_delta[i];
            else q_tail -= q_delta[i];
            drop_entry(i);
            found = 1'b1;
          end
        end
        push_result(found ? KIND_DONE : KIND_NOTFND, '0, '0, 1'b1);
      end
      MODE_ADVANCE: predict_advance(tv);
      MODE_SET: begin
        if (tv > q_now) begin
          predict_advance(tv - q_now);
        end else begin
          if (q_count > 0) begin
            add = q_now - tv;
            if (add > AllOnes - q_tail) add = AllOnes - q_tail;
            q_delta[0] += add;
            q_tail += add;
          end
          q_now = tv;
          push_result(KIND_DONE, '0, '0, 1'b1);
        end
      end
      MODE_CLEAR: begin
        q_count = 0;
        q_tail = '0;
        q_now = '0;
        push_result(KIND_DONE, '0, '0, 1'b1);
      end
      default: push_result(KIND_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  task automatic send_request(logic [2:0] mode, logic [31:0] id, logic [47:0] tmo,
                              logic rec, logic [63:0] tv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i <= mode;
    timer_tag_i <= id;
    timeout_units_i <= tmo;
    recurring_i <= rec;
    time_value_i <= tv;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(mode, id, tmo, rec, tv);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_scale(logic [31:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scale_q = value;
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_o, expired_id_o, remaining_units_o, now_units_o, last_o};
      results_seen++;
      if (got.kind == KIND_EXPIRY) expiries_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic logic [47:0] rand_tmo();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(3));
      default: return 48'($urandom_range(200));
    endcase
  endfunction

  task automatic random_request(bit small_ids);
    logic [31:0] id;
    logic [63:0] tv;
    int unsigned pick;
    id = small_ids ? $urandom_range(7) : $urandom;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: tv = {$urandom, $urandom};
      1: tv = q_now + 64'($urandom_range(50));
      default: tv = 64'($urandom_range(300));
    endcase
    if (pick < 40) send_request(MODE_ADD, id, rand_tmo(), 1'($urandom_range(1)), tv);
    else if (pick < 55) send_request(MODE_STOP, id, rand_tmo(), 1'b0, tv);
    else if (pick < 80) send_request(MODE_ADVANCE, id, '0, 1'b0, $urandom_range(3) == 0 ?
                                     {$urandom, $urandom} : 64'($urandom_range(150)));
    else if (pick < 93) send_request(MODE_SET, id, '0, 1'b0, tv);
    else if (pick < 97) send_request(MODE_CLEAR, id, '0, 1'b0, tv);
    else send_request(3'($urandom_range(7, 5)), $urandom, rand_tmo(), 1'b1, tv);
  endtask

  task automatic test_directed();
    send_request(MODE_STOP, 32'hFFFF_FFFF, '0, 1'b0, '0);
    send_request(MODE_ADVANCE, '0, '0, 1'b0, '0);
    send_request(MODE_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, AllOnes);
    send_request(MODE_ADD, 32'd5, 48'd10, 1'b1, '0);
    send_request(MODE_ADD, 32'd5, 48'd10, 1'b0, '0);
    send_request(MODE_ADD, 32'd7, 48'd0, 1'b0, '0);
    send_request(MODE_STOP, 32'd5, '0, 1'b0, '0);
    send_request(MODE_ADVANCE, '0, '0, 1'b0, 64'd25);
    send_request(MODE_SET, '0, '0, 1'b0, 64'd3);
    send_request(MODE_SET, '0, '0, 1'b0, 64'd100);
    send_request(MODE_SET, '0, '0, 1'b0, '0);
    send_request(MODE_ADVANCE, '0, '0, 1'b0, AllOnes);
    send_request(3'd5, '1, '1, 1'b1, AllOnes);
    send_request(3'd7, '0, '0, 1'b0, '0);
    send_request(MODE_CLEAR, '0, '0, 1'b0, '0);
    // Fill the table with period-1 recurring timers to hit the expiry cap.
    for (int i = 0; i < NumTimers; i++) send_request(MODE_ADD, i, 48'd1, 1'b1, '0);
    send_request(MODE_ADD, 32'd99, 48'd1, 1'b0, '0);
    send_request(MODE_ADVANCE, '0, '0, 1'b0, 64'd5);
    send_request(MODE_ADVANCE, '0, '0, 1'b0, AllOnes);
    send_request(MODE_CLEAR, '0, '0, 1'b0, '0);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      random_request($urandom_range(3) != 0);
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic test_scales();
    write_scale(32'hFFFF_FFFF);
    test_random(30);
    write_scale(32'd0);
    test_random(30);
    write_scale(32'd3);
    test_random(30);
    write_scale(32'd1);
  endtask

  initial begin
    scale_q = 32'd1;
    q_count = 0;
    q_tail = '0;
    q_now = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 0; stall_pct = 0; test_random(90);
    send_idle_pct = 77; stall_pct = 0; test_random(90);
    send_idle_pct = 0; stall_pct = 77; test_random(90);
    send_idle_pct = 28; stall_pct = 28; test_random(90);
    send_idle_pct = 0; stall_pct = 0; test_scales();
    wait_drained();
    $display("Sent %0d requests under four idle/stall mixes and four scale settings.",
             requests_sent);
    $display("Checked %0d results, %0d of them expiries; %0d mismatches.",
             results_seen, expiries_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[delta_list_timer_queue] OK");
    end else begin
      $display("[delta_list_timer_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("[delta_list_timer_queue] ERROR");
    $finish;
  end
endmodule
